// ===== src/url_token_blanker_assert.svh =====
// assertion macros for the token blanker
`ifndef URL_TOKEN_BLANKER_ASSERT_SVH
`define URL_TOKEN_BLANKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define UTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/utb_pkg.sv =====
`default_nettype none

package utb_pkg;

  // character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SHOW,
    S_TAIL
  } utb_state_t;

  // token delimiters
  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_QUOTE) || (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB);
  endfunction

endpackage

`default_nettype wire

// ===== src/utb_in_if.sv =====
`default_nettype none

// input channel: one text byte per transfer
interface utb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       buffer_end;

  modport source (output valid, output text_byte, output buffer_end, input ready);
  modport sink   (input valid, input text_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

// ===== src/utb_out_if.sv =====
`default_nettype none

// output channel: one emitted byte per transfer
interface utb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       too_long;

  modport source (output valid, output out_byte, output run_last, output too_long,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input too_long,
                  output ready);
endinterface

`default_nettype wire

// ===== src/url_token_blanker.sv =====
// Streaming filter that blanks URL-like tokens in text. Bytes enter on text_in; quote,
// space, newline and tab are delimiters, and the bytes between them are held in a
// token memory of MAX_TOKEN bytes. A token byte that neither ends the buffer nor
// overflows the memory is absorbed with no output. When a delimiter or
// buffer_end arrives, the token is replayed from the memory, as spaces if it looked
// like a URL, and the delimiter follows; run_last marks the final byte of each input.
// The single-port read of the token memory sets the replay pace: each stored byte is
// read in S_FETCH, then presented in S_SHOW, where it is held while the receiver stalls,
// and a trailing delimiter is presented in S_TAIL. Tokens longer than MAX_TOKEN are
// passed through unchanged with too_long set. No input is taken while results are
// being delivered.
`default_nettype none

module url_token_blanker #(
  parameter int MAX_TOKEN = 63
) (
  input  wire logic clk,
  input  wire logic rst,
  utb_in_if.sink    text_in,
  utb_out_if.source text_out
);
  import utb_pkg::*;

  localparam int LEN_W = $clog2(MAX_TOKEN + 1);
  localparam int IDX_W = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_TWO = LEN_W'(2);

  utb_state_t state, state_next;

  // token state
  logic [LEN_W-1:0] tok_len, tok_len_next;
  logic             dot_seen, dot_next;
  logic             blank_flag, blank_next;
  logic             pass_flag, pass_next;
  logic [7:0]       last_byte, last_next;

  // replay setup
  logic [LEN_W-1:0] emit_len, e_len_n;
  logic [LEN_W-1:0] emit_cnt;
  logic             emit_blank, e_blank_n;
  logic             emit_flag, e_flag_n;
  logic             tail_valid, t_valid_n;
  logic             tail_flag, t_flag_n;
  logic [7:0]       tail_byte;
  logic             load;

  // token memory
  logic [7:0]       store [MAX_TOKEN];
  logic             wr_en;
  logic             rd_en;
  logic [7:0]       rd_q;

  logic             in_xfer, out_xfer, delim, endf;
  logic [7:0]       c;
  logic             dot_j, blank_j;
  logic [LEN_W-1:0] cnt_inc;
  logic             emit_last;

  assign text_in.ready = (state == S_IDLE);
  assign in_xfer       = text_in.valid && text_in.ready;
  assign out_xfer      = text_out.valid && text_out.ready;
  assign c             = text_in.text_byte;
  assign endf          = text_in.buffer_end;
  assign delim         = is_delim(c);
  assign cnt_inc       = emit_cnt + LEN_ONE;
  assign emit_last     = (cnt_inc == emit_len);

  // judge the previous byte against the incoming one
  always_comb begin
    dot_j   = dot_seen;
    blank_j = blank_flag;
    if (!blank_flag && tok_len >= LEN_TWO) begin
      if ((last_byte == CH_SLASH && (dot_seen || c == CH_SLASH)) || last_byte == CH_AT) begin
        blank_j = 1'b1;
      end else if (last_byte == CH_DOT && c != CH_DOT) begin
        if (!dot_seen) begin
          dot_j = 1'b1;
        end else begin
          blank_j = 1'b1;
        end
      end
    end
  end

  // input decode: absorb, flush or pass through
  always_comb begin
    tok_len_next = tok_len;
    dot_next     = dot_seen;
    blank_next   = blank_flag;
    pass_next    = pass_flag;
    last_next    = last_byte;
    wr_en        = 1'b0;
    load         = 1'b0;
    e_len_n      = '0;
    e_blank_n    = 1'b0;
    e_flag_n     = 1'b0;
    t_valid_n    = 1'b0;
    t_flag_n     = 1'b0;
    if (in_xfer) begin
      if (!delim) begin
        if (pass_flag) begin
          load      = 1'b1;
          t_valid_n = 1'b1;
          t_flag_n  = 1'b1;
          pass_next = !endf;
        end else if (tok_len >= LEN_MAX) begin
          load         = 1'b1;
          e_len_n      = tok_len;
          e_flag_n     = 1'b1;
          t_valid_n    = 1'b1;
          t_flag_n     = 1'b1;
          tok_len_next = '0;
          dot_next     = 1'b0;
          blank_next   = 1'b0;
          pass_next    = !endf;
        end else begin
          wr_en     = 1'b1;
          last_next = c;
          if (endf) begin
            load         = 1'b1;
            e_len_n      = tok_len + LEN_ONE;
            e_blank_n    = blank_j;
            tok_len_next = '0;
            dot_next     = 1'b0;
            blank_next   = 1'b0;
          end else begin
            tok_len_next = tok_len + LEN_ONE;
            dot_next     = dot_j;
            blank_next   = blank_j;
          end
        end
      end else begin
        load         = 1'b1;
        e_len_n      = tok_len;
        e_blank_n    = blank_flag;
        t_valid_n    = 1'b1;
        tok_len_next = '0;
        dot_next     = 1'b0;
        blank_next   = 1'b0;
        pass_next    = 1'b0;
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and output drive
  always_comb begin
    state_next        = state;
    rd_en             = 1'b0;
    text_out.valid    = 1'b0;
    text_out.out_byte = tail_byte;
    text_out.run_last = 1'b1;
    text_out.too_long = tail_flag;
    unique case (state)
      S_IDLE: begin
        if (load) begin
          if (e_len_n != '0) begin
            state_next = S_FETCH;
          end else if (t_valid_n) begin
            state_next = S_TAIL;
          end
        end
      end
      S_FETCH: begin
        rd_en      = 1'b1;
        state_next = S_SHOW;
      end
      S_SHOW: begin
        text_out.valid    = 1'b1;
        text_out.out_byte = emit_blank ? CH_SPACE : rd_q;
        text_out.run_last = emit_last && !tail_valid;
        text_out.too_long = emit_flag;
        if (out_xfer) begin
          if (!emit_last) begin
            state_next = S_FETCH;
          end else if (tail_valid) begin
            state_next = S_TAIL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_TAIL: begin
        text_out.valid = 1'b1;
        if (out_xfer) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // token state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_len    <= '0;
      dot_seen   <= 1'b0;
      blank_flag <= 1'b0;
      pass_flag  <= 1'b0;
    end else begin
      tok_len    <= tok_len_next;
      dot_seen   <= dot_next;
      blank_flag <= blank_next;
      pass_flag  <= pass_next;
    end
  end

  always_ff @(posedge clk) begin
    last_byte <= last_next;
  end

  // replay control
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_len   <= '0;
      emit_cnt   <= '0;
      tail_valid <= 1'b0;
    end else if (load) begin
      emit_len   <= e_len_n;
      emit_cnt   <= '0;
      tail_valid <= t_valid_n;
    end else if (state == S_SHOW && out_xfer) begin
      emit_cnt <= cnt_inc;
    end
  end

  // replay payload
  always_ff @(posedge clk) begin
    if (load) begin
      emit_blank <= e_blank_n;
      emit_flag  <= e_flag_n;
      tail_flag  <= t_flag_n;
      tail_byte  <= c;
    end
  end

  // token memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[tok_len[IDX_W-1:0]] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= store[emit_cnt[IDX_W-1:0]];
    end
  end

  // checks
  `include "url_token_blanker_assert.svh"

  `UTB_ASSERT_NOW(a_no_overlap, text_out.valid, !text_in.ready, "input taken during output")
  `UTB_ASSERT_NOW(a_len_bound, 1'b1, tok_len <= LEN_MAX, "token length past memory depth")
  `UTB_ASSERT_NOW(a_pass_empty, pass_flag, tok_len == '0, "pass through with buffered bytes")
  `UTB_ASSERT_NEXT(a_last_idle, out_xfer && text_out.run_last, state == S_IDLE, "no idle after last")

endmodule

`default_nettype wire

// ===== tb/blanker_check.sv =====
`timescale 1ns / 1ps

module blanker_check #(
  parameter int TOKEN_CAP = 63
) (
  input  logic clk,
  input  logic rst,
  utb_in_if    text_in,
  utb_out_if   text_out,
  output int   fail_count,
  output int   pending
);

  import utb_pkg::*;

  // one emitted byte as the block should deliver it
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       flag;
  } emit_t;

  emit_t      emit_q[$];

  // mirror of the token state
  logic [7:0] tok_mem[TOKEN_CAP];
  int         tok_len;
  logic       dot_seen;
  logic       blank;
  logic       passthru;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic is_separator(input logic [7:0] c);
    return c == CH_QUOTE || c == CH_SPACE || c == CH_LF || c == CH_TAB;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic push_emit(input logic [7:0] ch, input logic flag);
    emit_t e;
    e.ch   = ch;
    e.last = 1'b0;
    e.flag = flag;
    emit_q.push_back(e);
  endtask

  task automatic clear_token();
    tok_len  = 0;
    dot_seen = 1'b0;
    blank    = 1'b0;
  endtask

  // interior byte judged against its successor
  task automatic judge_byte(input logic [7:0] cur, input logic [7:0] nxt);
    if (!blank) begin
      if ((cur == CH_SLASH && (dot_seen || nxt == CH_SLASH)) || cur == CH_AT) begin
        blank = 1'b1;
      end else if (cur == CH_DOT && nxt != CH_DOT) begin
        if (!dot_seen) dot_seen = 1'b1;
        else blank = 1'b1;
      end
    end
  endtask

  task automatic flush_token();
    for (int i = 0; i < tok_len; i++) push_emit(blank ? CH_SPACE : tok_mem[i], 1'b0);
    clear_token();
  endtask

  // expected output bytes for one accepted text byte
  task automatic predict_emits(input logic [7:0] c, input logic eob);
    int base;
    base = emit_q.size();
    if (!is_separator(c)) begin
      if (passthru) begin
        push_emit(c, 1'b1);
      end else if (tok_len >= TOKEN_CAP) begin
        for (int i = 0; i < tok_len; i++) push_emit(tok_mem[i], 1'b1);
        push_emit(c, 1'b1);
        clear_token();
        passthru = 1'b1;
      end else begin
        if (tok_len >= 2) judge_byte(tok_mem[tok_len-1], c);
        tok_mem[tok_len] = c;
        tok_len++;
      end
      if (eob) begin
        flush_token();
        passthru = 1'b0;
      end
    end else begin
      flush_token();
      push_emit(c, 1'b0);
      passthru = 1'b0;
    end
    if (emit_q.size() > base) emit_q[emit_q.size()-1].last = 1'b1;
  endtask

  // compare output transfers, then predict from input transfers
  always @(posedge clk) begin
    emit_t want;
    if (rst) begin
      emit_q.delete();
      clear_token();
      passthru = 1'b0;
    end else begin
      if (text_out.valid && text_out.ready) begin
        if (emit_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", text_out.out_byte));
        end else begin
          want = emit_q.pop_front();
          if (text_out.out_byte !== want.ch)
            report_mismatch($sformatf("out_byte %02h, want %02h",
                                      text_out.out_byte, want.ch));
          if (text_out.run_last !== want.last)
            report_mismatch($sformatf("run_last %b, want %b",
                                      text_out.run_last, want.last));
          if (text_out.too_long !== want.flag)
            report_mismatch($sformatf("too_long %b, want %b",
                                      text_out.too_long, want.flag));
        end
      end
      if (text_in.valid && text_in.ready)
        predict_emits(text_in.text_byte, text_in.buffer_end);
    end
    pending <= emit_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  import utb_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       in_end = 1'b0;
  logic       out_ready = 1'b0;
  logic       calm = 1'b0;
  int         sent = 0;
  int         fail_count;
  int         pending;

  utb_in_if  text_in_ch ();
  utb_out_if text_out_ch ();

  assign text_in_ch.valid      = in_valid;
  assign text_in_ch.text_byte  = in_byte;
  assign text_in_ch.buffer_end = in_end;
  assign text_out_ch.ready     = out_ready;

  url_token_blanker dut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in_ch),
    .text_out (text_out_ch)
  );

  blanker_check u_blank_check (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in_ch),
    .text_out   (text_out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver stalls, none during the calm stretch
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(0, 99) >= 15);
  end

  // one byte transfer, with an occasional gap ahead of it
  task automatic send_byte(input logic [7:0] c, input logic eob);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= c;
    in_end   <= eob;
    do @(posedge clk); while (!text_in_ch.ready);
    sent++;
    calm <= (sent >= 240 && sent < 330);
  endtask

  task automatic send_text(input string s, input logic end_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], end_last && i == s.len() - 1);
  endtask

  // hold off until every byte owed has been delivered
  task automatic drain_output();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] token_char();
    int         r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'(8'h61 + $urandom_range(0, 25));
    if (r < 55) return CH_DOT;
    if (r < 67) return CH_SLASH;
    if (r < 72) return CH_AT;
    do b = 8'($urandom_range(0, 255)); while (is_delim(b));
    return b;
  endfunction

  function automatic logic [7:0] delim_char();
    case ($urandom_range(0, 3))
      0: return CH_QUOTE;
      1: return CH_SPACE;
      2: return CH_LF;
      default: return CH_TAB;
    endcase
  endfunction

  initial begin
    int   len;
    logic end_on_tok;
    logic drained;
    drained = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // dot runs and a second dot, double slash, at sign
    send_text("a..b.c ", 1'b0);
    send_text("w//v\n", 1'b0);
    send_text("q@r\t", 1'b0);
    // one-byte tokens, extreme bytes, buffer end on token and on delimiter
    send_text("a\"", 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_text("d.x/y", 1'b1);
    send_byte(CH_SPACE, 1'b1);

    // random words, mostly short, a few beyond the token store
    while (sent < 430) begin
      if (sent >= 200 && !drained) begin
        drain_output();
        drained = 1'b1;
      end
      if ($urandom_range(0, 11) == 0) len = $urandom_range(60, 70);
      else len = $urandom_range(0, 8);
      end_on_tok = (len > 0) && ($urandom_range(0, 99) < 15);
      for (int k = 0; k < len; k++) send_byte(token_char(), end_on_tok && k == len - 1);
      if (!end_on_tok) send_byte(delim_char(), $urandom_range(0, 99) < 20);
    end

    drain_output();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("url_token_blanker verification clean");
    end else begin
      $display("url_token_blanker verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("url_token_blanker verification failed");
    $finish;
  end

endmodule
